// ===== rtl/rwnt_pkg.sv =====
// ----------------------------------------------------------------------------
// rwnt_pkg
// Shared types and constants for the receive window / nack tracker.
// ----------------------------------------------------------------------------
package rwnt_pkg;

  localparam int WINDOW     = 256;
  localparam int IDX_W      = $clog2(WINDOW);
  localparam int OFF_W      = IDX_W + 1;
  localparam int NACK_LIMIT = 16;
  localparam int PTR_W      = $clog2(NACK_LIMIT);
  localparam int CNT_W      = PTR_W + 1;

  localparam logic [1:0] OP_SEGMENT = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_CONSUME = 2'd2;

  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_STALE    = 3'd2;
  localparam logic [2:0] ST_BEYOND   = 3'd3;
  localparam logic [2:0] ST_NOSEG    = 3'd4;

  localparam logic [1:0] REG_GAP_PKT  = 2'd0;
  localparam logic [1:0] REG_GAP_TICK = 2'd1;
  localparam logic [1:0] REG_TICK_INT = 2'd2;
  localparam logic [1:0] REG_DLY_LIM  = 2'd3;

  // divide by 100 through reciprocal multiply, exact for numerators below 2^23
  localparam logic [23:0] RECIP_100 = 24'd10737419;
  localparam int          RECIP_SH  = 30;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] seq;
    logic [15:0] frame_index;
    logic [15:0] send_delay;
    logic [31:0] now_ms;
  } rwnt_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        ack_sent;
    logic [31:0] ack_base;
    logic [31:0] ack_acked;
    logic [4:0]  nack_count;
    logic [8:0]  nack_offset;
    logic        last;
    logic [15:0] smoothed_delay;
  } rwnt_out_t;

  typedef struct packed {
    logic             clear;
    logic             shift;
    logic             mark;
    logic             rng_en;
    logic [OFF_W-1:0] lo_off;
    logic [OFF_W-1:0] hi_off;
    logic             set_en;
  } rwnt_ctrl_t;

endpackage

// ===== rtl/receive_window_nack_tracker.sv =====
// ----------------------------------------------------------------------------
// receive_window_nack_tracker
// Receive window tracker with loss list and acknowledgement generation.
// ----------------------------------------------------------------------------
// one transaction at a time: input is taken only in the idle state
// segment: check, mark, base advance per received head, decide; dup/stale/beyond: check only
// consume: slides up to WINDOW-1 positions or clears the row, then advances the base
// an acknowledgement adds a scan of the loss cells and one result row per nack
// (one if none); the cell row shifts one position per cycle
// rst_n synchronous active low: window cleared, registers at defaults
module receive_window_nack_tracker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rwnt_pkg::rwnt_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rwnt_pkg::rwnt_out_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import rwnt_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_MARK   = 4'd2;
  localparam logic [3:0] S_ADV    = 4'd3;
  localparam logic [3:0] S_SLIDE  = 4'd4;
  localparam logic [3:0] S_DECIDE = 4'd5;
  localparam logic [3:0] S_PLAIN  = 4'd6;
  localparam logic [3:0] S_SCAN   = 4'd7;
  localparam logic [3:0] S_EMIT   = 4'd8;

  logic [15:0] gap_pkt_r, gap_tick_r, tick_int_r, dly_lim_r;
  logic [3:0]  state_r, state_nxt;
  rwnt_in_t    in_r;
  logic [31:0] base_r, base_nxt, max_r, max_nxt;
  logic [31:0] last_ack_r, last_ack_nxt, last_tick_r, last_tick_nxt;
  logic [15:0] est_r, est_nxt;
  logic [2:0]  status_r, status_nxt;
  logic [31:0] acked_r, acked_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] nfound_r, nfound_nxt;
  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic [OFF_W-1:0] stack_r [NACK_LIMIT];
  logic        push;
  logic        sm_go_r, sm_go_nxt, sm_mul_r, sm_fin_r;
  logic [22:0] num_r;
  logic [46:0] prod_r;
  logic        out_valid_r;
  rwnt_out_t   out_r, out_nxt;
  logic        out_load, slot_free;

  rwnt_ctrl_t       ctrl;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_rcv, rd_lost, head_rcv;

  logic [31:0] seq_off, nb, gap_ack, gap_tick, mb, mb_off;
  logic        dup, stale, seed, beyond;

  rwnt_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .rd_idx   (rd_idx),
    .rd_rcv   (rd_rcv),
    .rd_lost  (rd_lost),
    .head_rcv (head_rcv)
  );

  // configuration port
  assign pready = 1'b1;
  always_comb begin
    case (paddr[3:2])
      REG_GAP_PKT:  prdata = {16'd0, gap_pkt_r};
      REG_GAP_TICK: prdata = {16'd0, gap_tick_r};
      REG_TICK_INT: prdata = {16'd0, tick_int_r};
      REG_DLY_LIM:  prdata = {16'd0, dly_lim_r};
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_pkt_r  <= 16'd20;
      gap_tick_r <= 16'd200;
      tick_int_r <= 16'd5;
      dly_lim_r  <= 16'd500;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_GAP_PKT:  gap_pkt_r  <= pwdata[15:0];
        REG_GAP_TICK: gap_tick_r <= pwdata[15:0];
        REG_TICK_INT: tick_int_r <= pwdata[15:0];
        REG_DLY_LIM:  dly_lim_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // segment classification
  assign seq_off  = in_r.seq - base_r;
  assign dup      = (in_r.seq > base_r) && (seq_off <= 32'(WINDOW)) && rd_rcv;
  assign stale    = in_r.seq < base_r;
  assign seed     = (max_r == 32'd0) && (in_r.seq > {16'd0, in_r.frame_index});
  assign nb       = seed ? (in_r.seq - {16'd0, in_r.frame_index} - 32'd1) : base_r;
  assign beyond   = (in_r.seq - nb) > 32'(WINDOW);
  assign gap_ack  = in_r.now_ms - last_ack_r;
  assign gap_tick = in_r.now_ms - last_tick_r;
  assign mb       = (max_r > base_r) ? max_r : base_r;
  assign mb_off   = mb - base_r;

  always_comb begin
    rd_idx = (state_r == S_SCAN) ? cnt_r : seq_off[IDX_W-1:0] - IDX_W'(1);
  end

  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    max_nxt       = max_r;
    last_ack_nxt  = last_ack_r;
    last_tick_nxt = last_tick_r;
    status_nxt    = status_r;
    acked_nxt     = acked_r;
    cnt_nxt       = cnt_r;
    nfound_nxt    = nfound_r;
    ptr_nxt       = ptr_r;
    sm_go_nxt     = 1'b0;
    push          = 1'b0;
    out_load      = 1'b0;
    out_nxt       = '0;
    ctrl          = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        status_nxt = ST_NOSEG;
        state_nxt  = S_PLAIN;
        case (in_r.op)
          OP_SEGMENT: begin
            if (dup) begin
              status_nxt = ST_DUP;
            end else if (stale) begin
              status_nxt = ST_STALE;
            end else if (beyond) begin
              status_nxt = ST_BEYOND;
            end else begin
              status_nxt = ST_ACCEPTED;
              state_nxt  = S_MARK;
              sm_go_nxt  = in_r.send_delay <= dly_lim_r;
              if (seed) begin
                base_nxt   = nb;
                max_nxt    = nb;
                ctrl.clear = 1'b1;
              end
            end
          end
          OP_TICK: begin
            if (gap_tick > {16'd0, tick_int_r}) begin
              last_tick_nxt = in_r.now_ms;
              if (gap_ack > {16'd0, gap_tick_r}) begin
                last_ack_nxt = in_r.now_ms;
                acked_nxt    = 32'd0;
                cnt_nxt      = IDX_W'(WINDOW - 1);
                nfound_nxt   = '0;
                state_nxt    = S_SCAN;
              end
            end
          end
          OP_CONSUME: begin
            if (in_r.seq > base_r) begin
              if (seq_off >= 32'(WINDOW)) begin
                ctrl.clear = 1'b1;
                base_nxt   = in_r.seq;
                state_nxt  = S_ADV;
              end else begin
                cnt_nxt   = seq_off[IDX_W-1:0];
                state_nxt = S_SLIDE;
              end
            end
          end
          default: ;
        endcase
      end
      S_MARK: begin
        ctrl.mark   = 1'b1;
        ctrl.rng_en = mb_off < 32'(WINDOW);
        ctrl.lo_off = mb_off[OFF_W-1:0] + OFF_W'(1);
        ctrl.hi_off = seq_off[OFF_W-1:0];
        ctrl.set_en = seq_off != 32'd0;
        if (in_r.seq > max_r) begin
          max_nxt = in_r.seq;
        end
        state_nxt = S_ADV;
      end
      S_SLIDE: begin
        ctrl.shift = 1'b1;
        base_nxt   = base_r + 32'd1;
        cnt_nxt    = cnt_r - IDX_W'(1);
        if (cnt_r == IDX_W'(1)) begin
          state_nxt = S_ADV;
        end
      end
      S_ADV: begin
        if (head_rcv) begin
          ctrl.shift = 1'b1;
          base_nxt   = base_r + 32'd1;
        end else if (in_r.op == OP_SEGMENT) begin
          state_nxt = S_DECIDE;
        end else begin
          state_nxt = S_PLAIN;
        end
      end
      S_DECIDE: begin
        if (gap_ack > {16'd0, gap_pkt_r} || gap_ack > {16'd0, gap_tick_r}) begin
          last_ack_nxt = in_r.now_ms;
          acked_nxt    = in_r.seq;
          cnt_nxt      = IDX_W'(WINDOW - 1);
          nfound_nxt   = '0;
          state_nxt    = S_SCAN;
        end else begin
          state_nxt = S_PLAIN;
        end
      end
      S_PLAIN: begin
        out_nxt.status         = status_r;
        out_nxt.last           = 1'b1;
        out_nxt.smoothed_delay = est_r;
        if (slot_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (rd_lost && nfound_r < CNT_W'(NACK_LIMIT)) begin
          push       = 1'b1;
          nfound_nxt = nfound_r + CNT_W'(1);
        end
        cnt_nxt = cnt_r - IDX_W'(1);
        if (cnt_r == '0) begin
          ptr_nxt   = nfound_nxt[PTR_W-1:0] - PTR_W'(1);
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        out_nxt.status         = status_r;
        out_nxt.ack_sent       = 1'b1;
        out_nxt.ack_base       = base_r;
        out_nxt.ack_acked      = acked_r;
        out_nxt.nack_count     = 5'(nfound_r);
        out_nxt.smoothed_delay = est_r;
        if (nfound_r != '0) begin
          out_nxt.nack_offset = 9'(stack_r[ptr_r]);
        end
        out_nxt.last = (nfound_r == '0) || (ptr_r == '0);
        if (slot_free) begin
          out_load = 1'b1;
          ptr_nxt  = ptr_r - PTR_W'(1);
          if (out_nxt.last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    est_nxt = est_r;
    if (sm_fin_r) begin
      est_nxt = (est_r == 16'd0) ? in_r.send_delay : prod_r[RECIP_SH +: 16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= '0;
      max_r       <= '0;
      last_ack_r  <= '0;
      last_tick_r <= '0;
      est_r       <= '0;
      sm_go_r     <= 1'b0;
      sm_mul_r    <= 1'b0;
      sm_fin_r    <= 1'b0;
      out_valid_r <= 1'b0;
      nfound_r    <= '0;
      ptr_r       <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      max_r       <= max_nxt;
      last_ack_r  <= last_ack_nxt;
      last_tick_r <= last_tick_nxt;
      est_r       <= est_nxt;
      sm_go_r     <= sm_go_nxt;
      sm_mul_r    <= sm_go_r;
      sm_fin_r    <= sm_mul_r;
      nfound_r    <= nfound_nxt;
      ptr_r       <= ptr_nxt;
      cnt_r       <= cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    status_r <= status_nxt;
    acked_r  <= acked_nxt;
    if (out_load) begin
      out_r <= out_nxt;
    end
    if (push) begin
      stack_r[nfound_r[PTR_W-1:0]] <= {1'b0, cnt_r} + OFF_W'(1);
    end
    // smoothing pipeline: weighted sum, then reciprocal multiply
    num_r  <= 23'(est_r) * 23'(90) + 23'(in_r.send_delay) * 23'(10);
    prod_r <= 47'(num_r) * 47'(RECIP_100);
  end

endmodule

// ===== rtl/rwnt_cell.sv =====
// ----------------------------------------------------------------------------
// rwnt_cell
// One window position: received and lost flags, shifts toward the base.
// ----------------------------------------------------------------------------
module rwnt_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  rwnt_pkg::rwnt_ctrl_t    ctrl,
  input  logic [rwnt_pkg::IDX_W-1:0] idx,
  input  logic                    nb_rcv,
  input  logic                    nb_lost,
  output logic                    rcv,
  output logic                    lost
);
  import rwnt_pkg::*;

  logic             rcv_r, rcv_nxt, lost_r, lost_nxt;
  logic [OFF_W-1:0] off;

  assign off = {1'b0, idx} + OFF_W'(1);

  always_comb begin
    rcv_nxt  = rcv_r;
    lost_nxt = lost_r;
    if (ctrl.clear) begin
      rcv_nxt  = 1'b0;
      lost_nxt = 1'b0;
    end else if (ctrl.shift) begin
      rcv_nxt  = nb_rcv;
      lost_nxt = nb_lost;
    end else if (ctrl.mark) begin
      if (ctrl.set_en && off == ctrl.hi_off) begin
        rcv_nxt  = 1'b1;
        lost_nxt = 1'b0;
      end else if (ctrl.rng_en && off >= ctrl.lo_off && off < ctrl.hi_off) begin
        lost_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rcv_r  <= 1'b0;
      lost_r <= 1'b0;
    end else begin
      rcv_r  <= rcv_nxt;
      lost_r <= lost_nxt;
    end
  end

  assign rcv  = rcv_r;
  assign lost = lost_r;

endmodule

// ===== rtl/rwnt_window.sv =====
// ----------------------------------------------------------------------------
// rwnt_window
// Row of window cells with one indexed read port and a head output.
// ----------------------------------------------------------------------------
module rwnt_window (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rwnt_pkg::rwnt_ctrl_t       ctrl,
  input  logic [rwnt_pkg::IDX_W-1:0] rd_idx,
  output logic                       rd_rcv,
  output logic                       rd_lost,
  output logic                       head_rcv
);
  import rwnt_pkg::*;

  logic [WINDOW-1:0] rcv_v, lost_v;
  logic [WINDOW:0]   rcv_c, lost_c;

  assign rcv_c[WINDOW]  = 1'b0;
  assign lost_c[WINDOW] = 1'b0;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    rwnt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .idx     (IDX_W'(i)),
      .nb_rcv  (rcv_c[i+1]),
      .nb_lost (lost_c[i+1]),
      .rcv     (rcv_v[i]),
      .lost    (lost_v[i])
    );
    assign rcv_c[i]  = rcv_v[i];
    assign lost_c[i] = lost_v[i];
  end

  assign rd_rcv   = rcv_v[rd_idx];
  assign rd_lost  = lost_v[rd_idx];
  assign head_rcv = rcv_v[0];

endmodule

// ===== rtl/rwnt_checker.sv =====
// ----------------------------------------------------------------------------
// rwnt_checker
// Port-level checks on the receive window tracker.
// ----------------------------------------------------------------------------
module rwnt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input rwnt_pkg::rwnt_out_t out_data,
  input logic                pready
);
  import rwnt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_plain_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.ack_sent |->
      out_data.last && out_data.nack_count == 5'd0 && out_data.ack_base == 32'd0)
    else $error("plain result carries ack fields");

  a_nack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.ack_sent |->
      out_data.nack_count <= 5'(NACK_LIMIT) &&
      (out_data.nack_count != 5'd0 || (out_data.nack_offset == 9'd0 && out_data.last)))
    else $error("bad nack count or offset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind receive_window_nack_tracker rwnt_checker u_rwnt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .pready    (pready)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for receive_window_nack_tracker. A directed set of
// segments, ticks and consumes is followed by random traffic kept mostly
// inside the receive window. Each accepted transaction runs through a
// window predictor, and every acknowledgement row is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import rwnt_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 1000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  rwnt_in_t    in_data;
  logic        out_valid;
  logic        out_ready;
  rwnt_out_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  receive_window_nack_tracker dut (.*);

  // predictor state
  int unsigned gap_pkt, gap_tick, tick_int, dly_lim;
  int unsigned base_seq, max_seen, last_ack, last_tick, dly_est;
  bit [WINDOW-1:0] rcvd, lost;

  rwnt_in_t  pending_q[$];
  rwnt_out_t ack_rows_q[$];
  int n_items, n_rows, n_acks, n_errors, cycles;
  int gap_cnt, stall_cnt, hold_cnt;
  bit in_took, out_took, quiet;
  int unsigned now;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void slide_window(int unsigned d);
    if (d >= WINDOW) begin
      rcvd = '0;
      lost = '0;
    end else begin
      rcvd = rcvd >> d;
      lost = lost >> d;
    end
  endfunction

  function automatic void walk_base();
    while (rcvd[0]) begin
      slide_window(1);
      base_seq++;
    end
  endfunction

  function automatic void push_row(logic [2:0] st, bit ack, int unsigned ab, int unsigned acked,
                                   int cnt, int off, bit lst);
    rwnt_out_t r;
    r.status = st;
    r.ack_sent = ack;
    r.ack_base = ab;
    r.ack_acked = acked;
    r.nack_count = 5'(cnt);
    r.nack_offset = 9'(off);
    r.last = lst;
    r.smoothed_delay = dly_est[15:0];
    ack_rows_q = {ack_rows_q, r};
  endfunction

  function automatic void build_ack(logic [2:0] st, int unsigned acked, int unsigned t);
    int offs[$];
    for (int i = WINDOW - 1; i >= 0 && offs.size() < NACK_LIMIT; i--)
      if (lost[i]) offs.push_front(i + 1);
    last_ack = t;
    n_acks++;
    if (offs.size() == 0) push_row(st, 1, base_seq, acked, 0, 0, 1);
    else
      foreach (offs[k])
        push_row(st, 1, base_seq, acked, offs.size(), offs[k], k == offs.size() - 1);
  endfunction

  function automatic void window_step(rwnt_in_t it);
    int unsigned nb, sq, fi, sd, t, o;
    bit seed;
    longint lo;
    sq = it.seq;
    fi = 32'(it.frame_index);
    sd = 32'(it.send_delay);
    t = it.now_ms;
    nb = base_seq;
    seed = 0;
    case (it.op)
      OP_SEGMENT: begin
        if (sq > base_seq && sq - base_seq <= WINDOW && rcvd[sq - base_seq - 1]) begin
          push_row(ST_DUP, 0, 0, 0, 0, 0, 1);
          return;
        end
        if (sq < base_seq) begin
          push_row(ST_STALE, 0, 0, 0, 0, 0, 1);
          return;
        end
        if (max_seen == 0 && sq > fi) begin
          nb = sq - fi - 1;
          seed = 1;
        end
        if (sq - nb > WINDOW) begin
          push_row(ST_BEYOND, 0, 0, 0, 0, 0, 1);
          return;
        end
        if (seed) begin
          base_seq = nb;
          max_seen = nb;
          rcvd = '0;
          lost = '0;
        end
        if (sd <= dly_lim) dly_est = (dly_est == 0) ? sd : (90 * dly_est + 10 * sd) / 100;
        lo = longint'(max_seen > base_seq ? max_seen : base_seq) + 1;
        for (longint j = lo; j < longint'(sq); j++)
          if (j - base_seq >= 1 && j - base_seq <= WINDOW) lost[j - base_seq - 1] = 1'b1;
        if (sq > max_seen) max_seen = sq;
        o = sq - base_seq;
        if (o > 0) begin
          lost[o - 1] = 1'b0;
          rcvd[o - 1] = 1'b1;
          walk_base();
        end
        if (t - last_ack > gap_pkt || t - last_ack > gap_tick) build_ack(ST_ACCEPTED, sq, t);
        else push_row(ST_ACCEPTED, 0, 0, 0, 0, 0, 1);
      end
      OP_TICK: begin
        if (t - last_tick > tick_int) begin
          last_tick = t;
          if (t - last_ack > gap_tick) begin
            build_ack(ST_NOSEG, 0, t);
            return;
          end
        end
        push_row(ST_NOSEG, 0, 0, 0, 0, 0, 1);
      end
      OP_CONSUME: begin
        if (sq > base_seq) begin
          slide_window(sq - base_seq);
          base_seq = sq;
          walk_base();
        end
        push_row(ST_NOSEG, 0, 0, 0, 0, 0, 1);
      end
      default: push_row(ST_NOSEG, 0, 0, 0, 0, 0, 1);
    endcase
  endfunction

  // input side: accepted transactions feed the predictor; taken results are checked
  always @(posedge clk) begin
    cycles <= cycles + 1;
    in_took <= in_valid && in_ready;
    out_took <= out_valid && out_ready;
    if (in_valid && in_ready) begin
      window_step(in_data);
      n_items <= n_items + 1;
    end
    if (out_valid && out_ready) begin
      n_rows <= n_rows + 1;
      if (ack_rows_q.size() == 0) begin
        $error("unexpected result status=%0d", out_data.status);
        n_errors <= n_errors + 1;
      end else begin
        rwnt_out_t e;
        e = ack_rows_q[0];
        ack_rows_q.delete(0);
        if (e !== out_data) begin
          n_errors <= n_errors + 1;
          if (e.status !== out_data.status)
            $error("status exp %0d got %0d", e.status, out_data.status);
          if (e.ack_sent !== out_data.ack_sent)
            $error("ack_sent exp %0d got %0d", e.ack_sent, out_data.ack_sent);
          if (e.ack_base !== out_data.ack_base)
            $error("ack_base exp %0d got %0d", e.ack_base, out_data.ack_base);
          if (e.ack_acked !== out_data.ack_acked)
            $error("ack_acked exp %0d got %0d", e.ack_acked, out_data.ack_acked);
          if (e.nack_count !== out_data.nack_count)
            $error("nack_count exp %0d got %0d", e.nack_count, out_data.nack_count);
          if (e.nack_offset !== out_data.nack_offset)
            $error("nack_offset exp %0d got %0d", e.nack_offset, out_data.nack_offset);
          if (e.last !== out_data.last)
            $error("last exp %0d got %0d", e.last, out_data.last);
          if (e.smoothed_delay !== out_data.smoothed_delay)
            $error("smoothed_delay exp %0d got %0d", e.smoothed_delay, out_data.smoothed_delay);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("receive_window_nack_tracker verification failed");
      $finish;
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (gap_cnt > 0) begin
        gap_cnt <= gap_cnt - 1;
        in_valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        in_data <= pending_q[0];
        pending_q.delete(0);
        in_valid <= 1'b1;
        gap_cnt <= quiet ? 0 : $urandom_range(0, 6);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    int s;
    s = stall_cnt;
    if (out_took) s = quiet ? 0 : $urandom_range(0, 6);
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (s > 0) begin
      out_ready <= 1'b0;
      s--;
    end else begin
      out_ready <= 1'b1;
    end
    stall_cnt <= s;
  end

  task automatic reg_write(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_GAP_PKT:  gap_pkt = 32'(val);
      REG_GAP_TICK: gap_tick = 32'(val);
      REG_TICK_INT: tick_int = 32'(val);
      default:      dly_lim = 32'(val);
    endcase
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_valid || ack_rows_q.size() > 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic add(logic [1:0] op, int unsigned sq, logic [15:0] fi, logic [15:0] sd,
                     int unsigned t);
    rwnt_in_t it;
    it.op = op;
    it.seq = sq;
    it.frame_index = fi;
    it.send_delay = sd;
    it.now_ms = t;
    pending_q = {pending_q, it};
  endtask

  task automatic random_batch(int n);
    int r;
    int unsigned sq;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      now += ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 40);
      if (r < 60) sq = base_seq + $urandom_range(1, 40);
      else if (r < 66) sq = base_seq - $urandom_range(1, 5);
      else if (r < 72) sq = base_seq + WINDOW + $urandom_range(1, 100);
      else if (r < 76) sq = $urandom();
      else sq = base_seq + $urandom_range(0, 60);
      if (r < 80)
        add(OP_SEGMENT, sq, 16'($urandom()),
            ($urandom_range(0, 4) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 700)), now);
      else if (r < 90) add(OP_TICK, $urandom(), 16'($urandom()), 16'($urandom()), now);
      else if (r < 98) add(OP_CONSUME, sq, 16'($urandom()), 16'($urandom()), now);
      else add(OP_UNUSED, $urandom(), 16'($urandom()), 16'($urandom()), now);
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    gap_pkt = 20;
    gap_tick = 200;
    tick_int = 5;
    dly_lim = 500;
    quiet = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // directed: seeding, gaps, duplicate, stale, beyond window, ticks, consumes
    add(OP_SEGMENT, 1000, 3, 100, 50);
    add(OP_SEGMENT, 1030, 0, 200, 80);
    add(OP_SEGMENT, 1000, 0, 300, 90);
    add(OP_SEGMENT, 10, 0, 300, 95);
    add(OP_SEGMENT, 996 + 300, 0, 300, 96);
    add(OP_SEGMENT, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 97);
    add(OP_SEGMENT, 997, 16'hFFFF, 0, 98);
    add(OP_SEGMENT, 1240, 0, 500, 130);
    add(OP_TICK, 0, 0, 0, 400);
    add(OP_TICK, 0, 0, 0, 403);
    add(OP_TICK, 0, 0, 0, 700);
    add(OP_CONSUME, 1010, 0, 0, 701);
    add(OP_CONSUME, 5, 0, 0, 702);
    add(OP_SEGMENT, 1020, 0, 501, 703);
    add(OP_CONSUME, 5000, 0, 0, 704);
    add(OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    add(OP_SEGMENT, 5003, 0, 40, 32'hFFFF_FFF0);
    add(OP_TICK, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'h0000_0100);
    drain();
    now = 32'h100;

    reg_write(REG_GAP_PKT, 16'h0);
    reg_write(REG_GAP_TICK, 16'h0);
    reg_write(REG_TICK_INT, 16'h0);
    reg_write(REG_DLY_LIM, 16'hFFFF);
    random_batch(40);

    // long receiver hold while the sender keeps offering
    hold_cnt = 2000;
    quiet = 1;
    random_batch(30);
    quiet = 0;

    reg_write(REG_GAP_PKT, 16'hFFFF);
    reg_write(REG_GAP_TICK, 16'hFFFF);
    reg_write(REG_TICK_INT, 16'hFFFF);
    reg_write(REG_DLY_LIM, 16'h0);
    random_batch(30);

    reg_write(REG_GAP_PKT, 16'($urandom_range(0, 60)));
    reg_write(REG_GAP_TICK, 16'($urandom_range(0, 300)));
    reg_write(REG_TICK_INT, 16'($urandom_range(0, 20)));
    reg_write(REG_DLY_LIM, 16'($urandom_range(100, 1000)));
    random_batch(52);

    $display("covered %0d transactions, %0d result rows, %0d acknowledgements",
             n_items, n_rows, n_acks);
    $display("four register settings including both extremes, one long receiver hold");
    if (n_errors == 0 && ack_rows_q.size() == 0)
      $display("receive_window_nack_tracker verification clean");
    else
      $display("receive_window_nack_tracker verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rwnt_pkg.sv
rtl/rwnt_cell.sv
rtl/rwnt_window.sv
rtl/receive_window_nack_tracker.sv
rtl/rwnt_checker.sv
sim/tb_top.sv
